FILE: rtl/xtns_pkg.sv
`default_nettype none

package xtns_pkg;

  typedef enum logic [2:0] {
    MODE_OUTSIDE   = 3'd0,
    MODE_OPENED    = 3'd1,
    MODE_START_TAG = 3'd2,
    MODE_END_TAG   = 3'd3,
    MODE_DQUOTE    = 3'd4,
    MODE_SQUOTE    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2
  } fault_t;

  // shift control for the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  localparam int MODE_W = 3;
  localparam int OUT_W  = 20;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

endpackage

`default_nettype wire

FILE: rtl/xtns_stack_cell.sv
`default_nettype none

module xtns_stack_cell
  import xtns_pkg::*;
#(
  parameter int WIDTH = 23
) (
  input  wire logic             clk,
  input  wire stack_op_t        op,
  input  wire logic [WIDTH-1:0] from_prev,
  input  wire logic [WIDTH-1:0] from_next,
  output logic      [WIDTH-1:0] q
);

  // push moves entries one cell deeper, pop moves them one cell up
  always_ff @(posedge clk) begin
    if (op.push) begin
      q <= from_prev;
    end else if (op.pop) begin
      q <= from_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/xml_tag_nesting_scanner_core.sv
// results: m_* is registered from the byte that causes it, in the cycle after that byte is accepted
// throughput: one byte per cycle; s_tready drops only while a result waits on m_tready
// the open-element stack is a row of shift cells with the top entry in cell 0,
// so a push or pop is one shift of the whole row in a single cycle
// reset (rst, synchronous): mode outside, position, tag start, stack depth, halt and m_tvalid cleared;
// stack cell contents are left as they are
`default_nettype none

module xml_tag_nesting_scanner_core
  import xtns_pkg::*;
#(
  parameter int STACK_DEPTH   = 16,
  parameter int POSITION_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte
  input  wire logic        s_tuser,   // first_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // element_start, element_end, parent_start, has_parent
  output logic [1:0]       m_tuser    // fault
);

  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int FRAME_W = MODE_W + POSITION_BITS;
  localparam int EXT_W   = (POSITION_BITS > OUT_W) ? POSITION_BITS : OUT_W;

  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] current_start, current_start_next;
  logic [SP_W-1:0]          sp, sp_next;
  logic                     halted, halted_next;

  logic [FRAME_W-1:0] cell_q [STACK_DEPTH];
  logic [FRAME_W-1:0] new_frame;
  stack_op_t          op;

  logic in_fire;
  logic emit;
  logic [POSITION_BITS-1:0] res_start, res_parent;
  logic                     res_has_parent;
  fault_t                   res_fault;

  // values after the first-byte clear
  mode_t                    mode_eff;
  logic [POSITION_BITS-1:0] pos_eff, cs_eff;
  logic [SP_W-1:0]          sp_eff;
  logic                     halted_eff;
  logic                     sp_zero, sp_full, sp_deep;
  logic [POSITION_BITS-1:0] top_start, below_start;
  mode_t                    top_mode;

  logic [EXT_W-1:0] ext_start, ext_end, ext_parent;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  assign top_start   = cell_q[0][POSITION_BITS-1:0];
  assign top_mode    = mode_t'(cell_q[0][FRAME_W-1:POSITION_BITS]);
  assign below_start = cell_q[1][POSITION_BITS-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [FRAME_W-1:0] prev_d, next_d;
      if (gi == 0) begin : g_first
        assign prev_d = new_frame;
      end else begin : g_mid
        assign prev_d = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_last
        assign next_d = cell_q[gi];
      end else begin : g_inner
        assign next_d = cell_q[gi+1];
      end
      xtns_stack_cell #(.WIDTH(FRAME_W)) u_cell (
        .clk       (clk),
        .op        (op),
        .from_prev (prev_d),
        .from_next (next_d),
        .q         (cell_q[gi])
      );
    end
  endgenerate

  always_comb begin
    mode_eff   = s_tuser ? MODE_OUTSIDE : mode;
    pos_eff    = s_tuser ? '0 : byte_position;
    cs_eff     = s_tuser ? '0 : current_start;
    sp_eff     = s_tuser ? '0 : sp;
    halted_eff = s_tuser ? 1'b0 : halted;
    sp_zero    = (sp_eff == '0);
    sp_full    = (sp_eff == SP_W'(STACK_DEPTH));
    sp_deep    = (sp_eff > SP_W'(1));

    mode_next          = mode_eff;
    byte_position_next = pos_eff;
    current_start_next = cs_eff;
    sp_next            = sp_eff;
    halted_next        = halted_eff;
    new_frame          = {mode_eff, cs_eff};
    op                 = '0;
    emit               = 1'b0;
    res_start          = cs_eff;
    res_parent         = '0;
    res_has_parent     = 1'b0;
    res_fault          = FAULT_NONE;

    if (!halted_eff) begin
      byte_position_next = pos_eff + 1'b1;
      case (mode_eff)
        MODE_OPENED: begin
          if (s_tdata == CH_SLASH) begin
            mode_next = MODE_END_TAG;
          end else if (s_tdata == CH_QMARK) begin
            mode_next = MODE_OUTSIDE;
          end else begin
            mode_next = MODE_START_TAG;
          end
        end
        MODE_START_TAG, MODE_END_TAG: begin
          if (mode_eff == MODE_START_TAG && s_tdata == CH_SLASH) begin
            emit           = 1'b1;
            res_has_parent = !sp_zero;
            res_parent     = sp_zero ? '0 : top_start;
            mode_next      = MODE_OUTSIDE;
          end else if (mode_eff == MODE_END_TAG && s_tdata == CH_GT) begin
            emit = 1'b1;
            if (sp_zero) begin
              res_fault   = FAULT_UNDER;
              halted_next = 1'b1;
            end else begin
              op.pop             = 1'b1;
              sp_next            = sp_eff - 1'b1;
              mode_next          = top_mode;
              current_start_next = top_start;
              res_start          = top_start;
              res_has_parent     = sp_deep;
              res_parent         = sp_deep ? below_start : '0;
            end
          end else if ((mode_eff == MODE_START_TAG && s_tdata == CH_GT) ||
                       s_tdata == CH_DQUOTE || s_tdata == CH_SQUOTE) begin
            if (sp_full) begin
              emit        = 1'b1;
              res_fault   = FAULT_OVER;
              halted_next = 1'b1;
            end else begin
              op.push = 1'b1;
              sp_next = sp_eff + 1'b1;
              if (s_tdata == CH_GT) begin
                new_frame = {MODE_OUTSIDE, cs_eff};
                mode_next = MODE_OUTSIDE;
              end else if (s_tdata == CH_DQUOTE) begin
                mode_next = MODE_DQUOTE;
              end else begin
                mode_next = MODE_SQUOTE;
              end
            end
          end
        end
        MODE_DQUOTE, MODE_SQUOTE: begin
          if ((mode_eff == MODE_DQUOTE && s_tdata == CH_DQUOTE) ||
              (mode_eff == MODE_SQUOTE && s_tdata == CH_SQUOTE)) begin
            if (sp_zero) begin
              emit        = 1'b1;
              res_fault   = FAULT_UNDER;
              halted_next = 1'b1;
            end else begin
              op.pop             = 1'b1;
              sp_next            = sp_eff - 1'b1;
              mode_next          = top_mode;
              current_start_next = top_start;
            end
          end
        end
        default: begin
          if (s_tdata == CH_LT) begin
            mode_next          = MODE_OPENED;
            current_start_next = pos_eff;
          end
        end
      endcase
      if (res_fault != FAULT_NONE) begin
        res_start = '0;
      end
    end

    // cells shift only on an accepted item
    if (!in_fire) begin
      op = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OUTSIDE;
      byte_position <= '0;
      current_start <= '0;
      sp            <= '0;
      halted        <= 1'b0;
    end else if (in_fire) begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
      current_start <= current_start_next;
      sp            <= sp_next;
      halted        <= halted_next;
    end
  end

  assign ext_start  = EXT_W'(res_start);
  assign ext_end    = EXT_W'(pos_eff);
  assign ext_parent = EXT_W'(res_parent);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      m_tdata <= {3'b000, res_has_parent, ext_parent[OUT_W-1:0],
                  ext_end[OUT_W-1:0], ext_start[OUT_W-1:0]};
      m_tuser <= res_fault;
    end
  end

`ifndef SYNTH
  a_sp_bounded: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && emit && res_fault != FAULT_NONE) |=> halted)
    else $error("fault without halt");

  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    (halted && in_fire && !s_tuser) |=>
      ($stable(sp) && $stable(byte_position) && !$rose(m_tvalid)))
    else $error("halted scanner changed state");

  a_fault_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != FAULT_NONE) |-> (m_tdata[60] == 1'b0 && m_tdata[19:0] == '0))
    else $error("fault item carries element fields");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import xtns_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct packed {
    logic [19:0] elem_start;
    logic [19:0] elem_end;
    logic [19:0] parent_start;
    logic        has_parent;
    fault_t      fault;
  } closed_span_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // text_byte
  logic        s_tuser = 1'b0;   // first_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;          // element_start, element_end, parent_start, has_parent
  logic [1:0]  m_tuser;          // fault

  xml_tag_nesting_scanner_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scanner shadow state
  mode_t        scan_mode;
  logic [19:0]  next_pos;
  logic [19:0]  tag_start;
  int           depth;
  mode_t        saved_mode [STACK_DEPTH];
  logic [19:0]  saved_start [STACK_DEPTH];
  bit           halted;

  closed_span_t span_q[$];
  int           errors = 0;
  int           items_sent = 0;
  int           stall_left = 0;
  bit           idle_on = 1'b1;
  bit           pending_first = 1'b0;

  task automatic record_fault(input fault_t f, input logic [19:0] p);
    closed_span_t s;
    s.elem_start = '0;
    s.elem_end = p;
    s.parent_start = '0;
    s.has_parent = 1'b0;
    s.fault = f;
    span_q.insert(span_q.size(), s);
    halted = 1'b1;
  endtask

  task automatic push_context(input mode_t ret_mode, input mode_t next_mode,
                              input logic [19:0] p);
    if (depth >= STACK_DEPTH) begin
      record_fault(FAULT_OVER, p);
    end else begin
      saved_mode[depth] = ret_mode;
      saved_start[depth] = tag_start;
      depth++;
      scan_mode = next_mode;
    end
  endtask

  task automatic pop_context(input logic [19:0] p, output bit ok);
    if (depth == 0) begin
      record_fault(FAULT_UNDER, p);
      ok = 1'b0;
    end else begin
      depth--;
      scan_mode = saved_mode[depth];
      tag_start = saved_start[depth];
      ok = 1'b1;
    end
  endtask

  task automatic close_span(input logic [19:0] p);
    closed_span_t s;
    s.elem_start = tag_start;
    s.elem_end = p;
    s.has_parent = (depth > 0);
    s.parent_start = '0;
    if (depth > 0) s.parent_start = saved_start[depth - 1];
    s.fault = FAULT_NONE;
    span_q.insert(span_q.size(), s);
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic first);
    logic [19:0] p;
    bit ok;
    if (first) begin
      scan_mode = MODE_OUTSIDE;
      next_pos = '0;
      tag_start = '0;
      depth = 0;
      halted = 1'b0;
    end
    if (!halted) begin
      p = next_pos;
      next_pos = next_pos + 20'd1;
      case (scan_mode)
        MODE_OPENED: begin
          if (c == CH_SLASH) scan_mode = MODE_END_TAG;
          else if (c == CH_QMARK) scan_mode = MODE_OUTSIDE;
          else scan_mode = MODE_START_TAG;
        end
        MODE_START_TAG: begin
          if (c == CH_SLASH) begin
            close_span(p);
            scan_mode = MODE_OUTSIDE;
          end else if (c == CH_GT) begin
            push_context(MODE_OUTSIDE, MODE_OUTSIDE, p);
          end else if (c == CH_DQUOTE) begin
            push_context(scan_mode, MODE_DQUOTE, p);
          end else if (c == CH_SQUOTE) begin
            push_context(scan_mode, MODE_SQUOTE, p);
          end
        end
        MODE_END_TAG: begin
          if (c == CH_GT) begin
            pop_context(p, ok);
            if (ok) close_span(p);
          end else if (c == CH_DQUOTE) begin
            push_context(scan_mode, MODE_DQUOTE, p);
          end else if (c == CH_SQUOTE) begin
            push_context(scan_mode, MODE_SQUOTE, p);
          end
        end
        MODE_DQUOTE: if (c == CH_DQUOTE) pop_context(p, ok);
        MODE_SQUOTE: if (c == CH_SQUOTE) pop_context(p, ok);
        default: begin
          if (c == CH_LT) begin
            scan_mode = MODE_OPENED;
            tag_start = p;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : check_results
    closed_span_t want;
    if (rst) begin
      scan_mode = MODE_OUTSIDE;
      next_pos = '0;
      tag_start = '0;
      depth = 0;
      halted = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (span_q.size() == 0) begin
          $error("result with no element pending: tdata %h tuser %0d", m_tdata, m_tuser);
          errors++;
        end else begin
          want = span_q.pop_front();
          if (m_tdata[19:0] !== want.elem_start) begin
            $error("element_start: expected %0d, got %0d", want.elem_start, m_tdata[19:0]);
            errors++;
          end
          if (m_tdata[39:20] !== want.elem_end) begin
            $error("element_end: expected %0d, got %0d", want.elem_end, m_tdata[39:20]);
            errors++;
          end
          if (m_tdata[59:40] !== want.parent_start) begin
            $error("parent_start: expected %0d, got %0d", want.parent_start,
                   m_tdata[59:40]);
            errors++;
          end
          if (m_tdata[60] !== want.has_parent) begin
            $error("has_parent: expected %0d, got %0d", want.has_parent, m_tdata[60]);
            errors++;
          end
          if (m_tuser !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, m_tuser);
            errors++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tuser);
    end
  end

  // receiver holds m_tready low after a result while the randomly drawn stall_left counts down
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= pending_first;
    pending_first = 1'b0;
    items_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] any_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  // any byte that leaves a tag in its current mode
  function automatic logic [7:0] tag_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_SLASH || c == CH_GT || c == CH_DQUOTE || c == CH_SQUOTE);
    return c;
  endfunction

  task automatic send_attrs();
    logic [7:0] q;
    repeat ($urandom_range(0, 2)) begin
      send_byte(" ");
      q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      send_byte(q);
      repeat ($urandom_range(0, 4)) send_byte(any_byte_except(q, q));
      send_byte(q);
    end
  endtask

  task automatic send_start_tag(input bit self_close);
    send_byte(CH_LT);
    send_byte(any_byte_except(CH_SLASH, CH_QMARK));
    repeat ($urandom_range(0, 2)) send_byte(tag_byte());
    send_attrs();
    if (self_close) begin
      send_byte(CH_SLASH);
      if ($urandom_range(0, 3) != 0) send_byte(CH_GT);
    end else begin
      send_byte(CH_GT);
    end
  endtask

  task automatic send_end_tag();
    send_byte(CH_LT);
    send_byte(CH_SLASH);
    repeat ($urandom_range(1, 3)) send_byte(tag_byte());
    if ($urandom_range(0, 4) == 0) send_attrs();
    send_byte(CH_GT);
  endtask

  task automatic random_document();
    int open_cnt;
    int limit;
    int pick;
    pending_first = ($urandom_range(0, 9) != 0);
    // now and then nest past the stack depth
    limit = ($urandom_range(0, 7) == 0) ? STACK_DEPTH + 2 : 8;
    open_cnt = 0;
    repeat ($urandom_range(3, 25)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35 && open_cnt < limit) begin
        send_start_tag(1'b0);
        open_cnt++;
      end else if (pick < 55 && open_cnt > 0) begin
        send_end_tag();
        open_cnt--;
      end else if (pick < 70) begin
        send_start_tag(1'b1);
      end else if (pick < 80) begin
        send_byte(CH_LT);
        send_byte(CH_QMARK);
        repeat ($urandom_range(0, 5)) send_byte(any_byte_except(CH_LT, CH_LT));
        send_byte(CH_GT);
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(any_byte_except(CH_LT, CH_LT));
      end
    end
    if ($urandom_range(0, 3) != 0) repeat (open_cnt) send_end_tag();
    if ($urandom_range(0, 7) == 0) send_end_tag();
  endtask

  task automatic send_noise();
    logic [7:0] c;
    pending_first = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(5, 30)) begin
      case ($urandom_range(0, 7))
        0: c = CH_LT;
        1: c = CH_SLASH;
        2: c = CH_QMARK;
        3: c = CH_GT;
        4: c = CH_DQUOTE;
        5: c = CH_SQUOTE;
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_byte(c);
    end
  endtask

  task automatic test_nesting_and_self_close();
    pending_first = 1'b1;
    send_text("<r><a/><b></b></r>");
  endtask

  task automatic test_quotes_and_pi();
    pending_first = 1'b1;
    send_text("<?x?><t a='\"' b=\"'>\">");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("<>></ '>'>");
    send_text("</t>");
  endtask

  task automatic test_underflow_halt();
    pending_first = 1'b1;
    send_text("</a>");
    // halted: nothing before the next first byte may produce a result
    send_text("<a/>");
    pending_first = 1'b1;
    send_text("<a/>");
  endtask

  task automatic test_overflow();
    pending_first = 1'b1;
    repeat (STACK_DEPTH + 1) send_text("<a>");
    pending_first = 1'b1;
    repeat (STACK_DEPTH) send_text("<a>");
    send_text("<b/>");
    send_text("<c '");
    pending_first = 1'b1;
    repeat (STACK_DEPTH) send_text("<a>");
    send_text("</a '");
    pending_first = 1'b1;
    repeat (STACK_DEPTH) send_text("<a>");
    repeat (STACK_DEPTH + 1) send_text("</a>");
  endtask

  task automatic test_random_documents();
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) idle_on = ~idle_on;
      if ($urandom_range(0, 9) == 0) send_noise();
      else random_document();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_nesting_and_self_close();
    test_quotes_and_pi();
    test_underflow_halt();
    test_overflow();
    test_random_documents();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (span_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
